// File: sv/pvenc_pkg.sv
// Shared types and constants for the prefix varint encoder.
// No dependencies; the encode stage, serializer and top level import this package.
package pvenc_pkg;

	typedef enum logic [1:0] {
		FMT_U16 = 2'd0,
		FMT_U32 = 2'd1,
		FMT_S16 = 2'd2,
		FMT_S32 = 2'd3
	} fmt_t;

	localparam int unsigned MAX_BYTES = 5;
	localparam int unsigned LEN_W     = 3;

	// Range limits of the shorter forms, as cumulative thresholds on the code.
	localparam logic [31:0] LIM1     = 32'h0000_0080;
	localparam logic [31:0] LIM16_2  = 32'h0000_4080;
	localparam logic [31:0] LIM32_2  = 32'h0000_2080;
	localparam logic [31:0] LIM32_3  = 32'h0020_2080;
	localparam logic [31:0] LIM32_4  = 32'h2020_2080;

	localparam logic [1:0] TAG16_2 = 2'b01;
	localparam logic [1:0] TAG16_3 = 2'b11;
	localparam logic [2:0] TAG32_2 = 3'h1;
	localparam logic [2:0] TAG32_3 = 3'h3;
	localparam logic [2:0] TAG32_4 = 3'h5;
	localparam logic [2:0] TAG32_5 = 3'h7;

	// One encoded value: bytes packed least significant first, plus count.
	typedef struct packed {
		logic [8*MAX_BYTES-1:0] bytes;
		logic [LEN_W-1:0]       len;
	} enc_t;

endpackage

// File: sv/pvenc_if.sv
// Valid/ready channel interfaces for the prefix varint encoder.
// Depends on nothing; used by the encode stage, serializer and top level.
interface pvenc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

interface pvenc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source (output valid, out_byte, last_byte, input ready);
	modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// File: sv/pvenc_encode.sv
// Input register and single-pass encoder: zigzag, range select, byte packing.
// Depends on pvenc_pkg and pvenc_in_if.
module pvenc_encode (
	input  logic            clk,
	input  logic            arst_n,
	pvenc_in_if.sink        in_ch,
	output pvenc_pkg::enc_t enc,
	output logic            enc_valid,
	input  logic            enc_ready
);
	import pvenc_pkg::*;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [31:0] value_s1;
	logic        take_in;

	logic [15:0] code16;
	logic [31:0] code32;
	logic [15:0] w16;
	logic [31:0] w32;
	enc_t        enc16;
	enc_t        enc32;

	assign in_ch.ready = !valid_s1 || enc_ready;
	assign take_in     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= in_ch.action;
			value_s1  <= in_ch.value;
		end
	end

	// Zigzag: shift left and flip every bit when the value is negative.
	always_comb begin
		if (action_s1 == FMT_S16) begin
			code16 = {value_s1[14:0], 1'b0} ^ {16{value_s1[15]}};
		end else begin
			code16 = value_s1[15:0];
		end
		if (action_s1 == FMT_S32) begin
			code32 = {value_s1[30:0], 1'b0} ^ {32{value_s1[31]}};
		end else begin
			code32 = value_s1;
		end
	end

	always_comb begin
		enc16 = '0;
		w16   = '0;
		if (code16 < LIM1[15:0]) begin
			enc16.bytes[7:0] = {code16[6:0], 1'b0};
			enc16.len        = LEN_W'(1);
		end else if (code16 < LIM16_2[15:0]) begin
			w16               = code16 - LIM1[15:0];
			enc16.bytes[15:0] = {w16[13:6], w16[5:0], TAG16_2};
			enc16.len         = LEN_W'(2);
		end else begin
			w16               = code16 - LIM16_2[15:0];
			enc16.bytes[23:0] = {6'd0, w16[15:14], w16[13:6], w16[5:0], TAG16_3};
			enc16.len         = LEN_W'(3);
		end
	end

	always_comb begin
		enc32 = '0;
		w32   = '0;
		if (code32 < LIM1) begin
			enc32.bytes[7:0] = {code32[6:0], 1'b0};
			enc32.len        = LEN_W'(1);
		end else begin
			if (code32 < LIM32_2) begin
				w32       = code32 - LIM1;
				enc32.len = LEN_W'(2);
			end else if (code32 < LIM32_3) begin
				w32       = code32 - LIM32_2;
				enc32.len = LEN_W'(3);
			end else if (code32 < LIM32_4) begin
				w32       = code32 - LIM32_3;
				enc32.len = LEN_W'(4);
			end else begin
				w32       = code32 - LIM32_4;
				enc32.len = LEN_W'(5);
			end
			enc32.bytes[39:8] = {5'd0, w32[31:5]};
			case (enc32.len)
				LEN_W'(2): enc32.bytes[7:0] = {w32[4:0], TAG32_2};
				LEN_W'(3): enc32.bytes[7:0] = {w32[4:0], TAG32_3};
				LEN_W'(4): enc32.bytes[7:0] = {w32[4:0], TAG32_4};
				default:   enc32.bytes[7:0] = {w32[4:0], TAG32_5};
			endcase
		end
	end

	assign enc_valid = valid_s1;
	assign enc = (action_s1 == FMT_U16 || action_s1 == FMT_S16) ? enc16 : enc32;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (enc.len >= LEN_W'(1) && enc.len <= LEN_W'(MAX_BYTES)))
		else $error("encoded length out of range");

	a_len16: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (action_s1 == FMT_U16 || action_s1 == FMT_S16)
		|-> enc.len <= LEN_W'(3))
		else $error("16-bit format encoded to more than three bytes");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !enc_ready |=> valid_s1 && $stable(enc))
		else $error("stalled encoded item changed");

endmodule

// File: sv/pvenc_serial.sv
// Output register that shifts an encoded value out one byte per cycle while out_ch.ready is high.
// Depends on pvenc_pkg and pvenc_out_if.
module pvenc_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  pvenc_pkg::enc_t enc,
	input  logic            enc_valid,
	output logic            enc_ready,
	pvenc_out_if.source     out_ch
);
	import pvenc_pkg::*;

	logic [8*MAX_BYTES-1:0] bytes_q;
	logic [LEN_W-1:0]       rem_q;
	logic                   take_out;
	logic                   load;

	assign out_ch.valid     = (rem_q != '0);
	assign out_ch.out_byte  = bytes_q[7:0];
	assign out_ch.last_byte = (rem_q == LEN_W'(1));
	assign take_out         = out_ch.valid && out_ch.ready;

	// A new item may load while the final byte of the previous one is taken.
	assign enc_ready = !out_ch.valid || (take_out && out_ch.last_byte);
	assign load      = enc_valid && enc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= enc.len;
		end else if (take_out) begin
			rem_q <= rem_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= enc.bytes;
		end else if (take_out) begin
			bytes_q <= {8'd0, bytes_q[8*MAX_BYTES-1:8]};
		end
	end

	a_rem_max: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= LEN_W'(MAX_BYTES))
		else $error("byte count exceeds maximum encoding length");

	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		take_out && !out_ch.last_byte |=> out_ch.valid)
		else $error("encoding stopped before its final byte");

endmodule

// File: sv/prefix_varint_encoder.sv
// Prefix varint encoder: one integer in, a run of one to five bytes out.
// Usage:
//   in_ch carries action (format: unsigned16, unsigned32, signed16,
//   signed32) and a 32-bit value. An item is taken when valid and ready
//   are both high. out_ch delivers the encoding least significant byte
//   first, one byte per accepted transfer, with last_byte set on the final
//   byte of each value.
// Path: with the output idle, the first byte of an item is presented once
//   the item has passed the input register and then the output shift
//   register.
// Throughput: one byte per cycle on out_ch while out_ch.ready is high; an
//   item has 1 to 3 bytes for 16-bit formats and 1 to 5 bytes for 32-bit
//   formats. The output port width of one byte sets this rate.
//   The next item is encoded while the current one is still shifting out and
//   loads in the same cycle its predecessor's final byte is taken.
// Reset: arst_n clears all valid flags; no item is in flight afterward.
// Stall: when out_ch.ready is low the current byte holds, one encoded item
//   waits in the input register, and in_ch.ready then drops.
// Depends on pvenc_pkg, pvenc_if, pvenc_encode and pvenc_serial.
module prefix_varint_encoder (
	input  logic        clk,
	input  logic        arst_n,
	pvenc_in_if.sink    in_ch,
	pvenc_out_if.source out_ch
);
	import pvenc_pkg::*;

	enc_t enc;
	logic enc_valid;
	logic enc_ready;

	pvenc_encode u_encode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.enc       (enc),
		.enc_valid (enc_valid),
		.enc_ready (enc_ready)
	);

	pvenc_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc       (enc),
		.enc_valid (enc_valid),
		.enc_ready (enc_ready),
		.out_ch    (out_ch)
	);

endmodule

// File: test/tb_prefix_varint_encoder.sv
// Testbench for prefix_varint_encoder: drives formatted integers, predicts the byte runs.
// Depends on pvenc_pkg, pvenc_if and the encoder RTL; needs no files at run time.
`timescale 1ns / 100ps

module tb_prefix_varint_encoder;
	import pvenc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES    = 60;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	// Holds the bytes each accepted value must produce, oldest first.
	class encoded_byte_board;
		enc_byte_t   expected_bytes[$];
		int unsigned n_errors;

		function new();
			n_errors = 0;
		endfunction

		task report(string what);
			n_errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		function void push_byte(logic [7:0] data, logic last);
			enc_byte_t e;
			e.data = data;
			e.last = last;
			expected_bytes.push_back(e);
		endfunction

		function void note_value(fmt_t f, logic [31:0] v);
			logic [31:0] code;
			logic [31:0] r;
			logic [1:0]  len_code;
			int unsigned len;
			int unsigned k;
			case (f)
				FMT_U16: code = {16'h0, v[15:0]};
				FMT_U32: code = v;
				FMT_S16: code = {16'h0, (v[15] ? {~v[14:0], 1'b1} : {v[14:0], 1'b0})};
				default: code = v[31] ? {~v[30:0], 1'b1} : {v[30:0], 1'b0};
			endcase
			if (code < 32'h80) begin
				push_byte({code[6:0], 1'b0}, 1'b1);
				return;
			end
			r = code - 32'h80;
			if (f == FMT_U16 || f == FMT_S16) begin
				len = 2;
				if (r >= 32'h4000) begin
					r = r - 32'h4000;
					len = 3;
				end
				// Tag in bits 1..0 is 01 for two bytes and 11 for three.
				push_byte({r[5:0], (len == 3), 1'b1}, 1'b0);
				push_byte(r[13:6], (len == 2));
				if (len == 3)
					push_byte(r[21:14], 1'b1);
			end else begin
				len = 2;
				if (r >= 32'h2000) begin
					r = r - 32'h2000;
					len = 3;
					if (r >= 32'h20_0000) begin
						r = r - 32'h20_0000;
						len = 4;
						if (r >= 32'h2000_0000) begin
							r = r - 32'h2000_0000;
							len = 5;
						end
					end
				end
				len_code = 2'(len - 2);
				push_byte({r[4:0], len_code, 1'b1}, 1'b0);
				for (k = 1; k < len; k++)
					push_byte(8'(r >> (5 + 8 * (k - 1))), (k == len - 1));
			end
		endfunction

		task check_byte(logic [7:0] data, logic last);
			enc_byte_t e;
			if (expected_bytes.size() == 0) begin
				report($sformatf("byte %02h last %0b with nothing expected", data, last));
				return;
			end
			e = expected_bytes.pop_front();
			if (data !== e.data)
				report($sformatf("out_byte %02h, expected %02h", data, e.data));
			if (last !== e.last)
				report($sformatf("last_byte %0b, expected %0b", last, e.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic hold_off;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles = 0;

	encoded_byte_board book = new();

	pvenc_in_if  in_ch();
	pvenc_out_if out_ch();

	prefix_varint_encoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Inputs are noted before outputs are checked, so same-edge order cannot matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				book.note_value(fmt_t'(in_ch.action), in_ch.value);
			if (out_ch.valid && out_ch.ready)
				book.check_byte(out_ch.out_byte, out_ch.last_byte);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	task automatic send_value(input fmt_t f, input logic [31:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.action <= f;
		in_ch.value  <= v;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_boundaries();
		fmt_t        fmts[25];
		logic [31:0] vals[25];
		fmts = '{FMT_U16, FMT_U16, FMT_U16, FMT_U16, FMT_U16, FMT_U16, FMT_U16,
			FMT_U32, FMT_U32, FMT_U32, FMT_U32, FMT_U32, FMT_U32, FMT_U32, FMT_U32,
			FMT_U32, FMT_S16, FMT_S16, FMT_S16, FMT_S16, FMT_S16,
			FMT_S32, FMT_S32, FMT_S32, FMT_S32};
		// Edges of every length form, then the signed extremes. The 16-bit items
		// with junk in the upper half check that those bits are ignored.
		vals = '{32'h0, 32'h7F, 32'h80, 32'h407F, 32'h4080, 32'hFFFF, 32'hABCD_0012,
			32'h7F, 32'h80, 32'h207F, 32'h2080, 32'h20_207F, 32'h20_2080,
			32'h2020_207F, 32'h2020_2080, 32'hFFFF_FFFF,
			32'h0, 32'hFFFF, 32'h7FFF, 32'h8000, 32'h1234_FFC0,
			32'h3F, 32'hFFFF_FFC0, 32'h7FFF_FFFF, 32'h8000_0000};
		foreach (vals[i])
			send_value(fmts[i], vals[i]);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] edges[5];
		edges = '{32'h80, 32'h4080, 32'h2080, 32'h20_2080, 32'h2020_2080};
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			2: return ~($urandom >> $urandom_range(0, 31));
			default: return edges[$urandom_range(0, 4)] + $urandom_range(0, 3) - 2;
		endcase
	endfunction

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_value(fmt_t'($urandom_range(0, 3)), pick_value());
	endtask

	initial begin
		arst_n         = 1'b0;
		hold_off       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		in_ch.valid    = 1'b0;
		in_ch.action   = FMT_U16;
		in_ch.value    = 32'h0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_boundaries();

		// Hold the receiver off while items keep coming, so the input backs up.
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			send_random(20);
		join

		send_random(75);
		send_idle_pct = 67;
		send_random(75);
		send_idle_pct  = 0;
		recv_stall_pct = 67;
		send_random(75);
		send_idle_pct  = 35;
		recv_stall_pct = 35;
		send_random(75);

		in_ch.valid <= 1'b0;
		while (book.expected_bytes.size() != 0)
			@(posedge clk);
		// Give the block room to show any stray byte after the last one.
		repeat (20) @(posedge clk);

		if (book.n_errors == 0 && book.expected_bytes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
